### sv/rv32ss_pkg.sv
// Shared constants for the RV32I subset execute step: opcodes, ALU function
// codes, default depths and configuration widths. No dependencies.
package rv32ss_pkg;

    // major opcodes handled by the block
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;

    // funct3 codes of the ALU
    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_AND = 3'b111;

    // default depths of the data memory and the program store
    localparam int DMEM_DEPTH_DEF = 1024;
    localparam int PROG_DEPTH_DEF = 4096;
    localparam int PROG_IDX_W     = 12;

    // program length register
    localparam int              CFG_W          = 13;
    localparam logic [CFG_W-1:0] PROG_LEN_RESET = 13'd4096;

    // result queue depth (power of two)
    localparam int FIFO_DEPTH = 4;

endpackage

### sv/rv32ss_if.sv
// Valid/ready channel interfaces of the execute step: instruction in,
// program length write, result out. Depends on rv32ss_pkg.
interface rv32ss_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface rv32ss_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rv32ss_pkg::CFG_W-1:0] program_length;

    modport source (output valid, output program_length, input ready);
    modport sink   (input valid, input program_length, output ready);
endinterface

interface rv32ss_result_if #(
    parameter int IDX_W = rv32ss_pkg::PROG_IDX_W
);
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   next_index;
    logic               index_fault;
    logic               illegal;
    logic               reg_written;
    logic [4:0]         dest_reg;
    logic signed [31:0] write_value;
    logic               mem_written;
    logic               mem_fault;
    logic               branch_taken;

    modport source (output valid, output next_index, output index_fault, output illegal,
                    output reg_written, output dest_reg, output write_value,
                    output mem_written, output mem_fault, output branch_taken,
                    input ready);
    modport sink   (input valid, input next_index, input index_fault, input illegal,
                    input reg_written, input dest_reg, input write_value,
                    input mem_written, input mem_fault, input branch_taken,
                    output ready);
endinterface

### sv/rv32ss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents. No dependencies.
module rv32ss_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rv32_subset_execute_step.sv
// Top level of the RV32I subset execute step: register file and data memory
// in RAMs, a three-step read/execute/write-back flow and a result queue.
// Depends on rv32ss_pkg, rv32ss_if.sv interfaces and rv32ss_ram.
//
//  channel    dir  modport  payload               transfer
//  i_instr    in   sink     instruction[31:0]     valid & ready
//  i_cfg      in   sink     program_length[12:0]  valid & ready (ready tied high)
//  o_result   out  source   nine result fields    valid & ready
//
// One instruction per cycle while i_instr.ready is high; each result passes the
// register file read, execute with data memory access and load data merged
// into the result queue before it is offered on o_result.
// After reset the data memory is cleared one word a cycle, with i_instr.ready
// low until the clear is done. Reset is synchronous, active low.
// The four-entry result queue absorbs output stalls; ready drops when four
// instructions are in flight or waiting. PROG_DEPTH must be a power of two; the block does not check it.
module rv32_subset_execute_step #(
    parameter int DMEM_DEPTH = rv32ss_pkg::DMEM_DEPTH_DEF,
    parameter int PROG_DEPTH = rv32ss_pkg::PROG_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rv32ss_instr_if.sink    i_instr,
    rv32ss_cfg_if.sink      i_cfg,
    rv32ss_result_if.source o_result
);

    localparam int IW = $clog2(PROG_DEPTH);
    localparam int AW = $clog2(DMEM_DEPTH);
    localparam int TW = ((IW > rv32ss_pkg::CFG_W) ? IW : rv32ss_pkg::CFG_W) + 2;
    localparam int FD = rv32ss_pkg::FIFO_DEPTH;
    localparam int FW = $clog2(FD);

    typedef struct packed {
        logic [IW-1:0] next_index;
        logic          index_fault;
        logic          illegal;
        logic          reg_written;
        logic [4:0]    dest_reg;
        logic [31:0]   write_value;
        logic          mem_written;
        logic          mem_fault;
        logic          branch_taken;
    } t_result;

    // control and state registers
    logic                         r_clearing;
    logic [AW-1:0]                r_clr_addr;
    logic [rv32ss_pkg::CFG_W-1:0] r_prog_len;
    logic [IW-1:0]                r_index;
    logic [31:0]                  r_rf_valid;
    logic                         r_s1_valid;
    logic [31:0]                  r_s1_instr;
    logic                         r_s2_valid;
    t_result                      r_s2;
    logic                         r_s2_load;
    logic                         r_wb_valid;
    logic [4:0]                   r_wb_rd;
    logic [31:0]                  r_wb_value;
    t_result                      r_fifo [FD];
    logic [FW-1:0]                r_wptr;
    logic [FW-1:0]                r_rptr;
    logic [FW:0]                  r_count;
    logic [FW:0]                  r_credit;

    logic in_xfer;
    logic out_xfer;
    logic cfg_xfer;

    logic [31:0] rf1_q;
    logic [31:0] rf2_q;
    logic [31:0] dmem_q;

    // execute step signals
    logic [6:0]  s1_opc;
    logic [4:0]  s1_rd;
    logic [2:0]  s1_f3;
    logic [4:0]  s1_rs1;
    logic [4:0]  s1_rs2;
    logic [31:0] s1_a;
    logic [31:0] s1_b;
    logic [31:0] s1_imm_i;
    logic [31:0] s1_imm_s;
    logic [31:0] s1_addr;
    logic [31:0] s1_op2;
    logic [31:0] s1_alu;
    logic        s1_is_load;
    logic        s1_is_store;
    logic        s1_is_alu;
    logic        s1_is_op;
    logic        s1_is_branch;
    logic        s1_illegal;
    logic        s1_mem_fault;
    logic        s1_wr;
    logic        s1_taken;
    logic [12:0] s1_boff;
    logic [10:0] s1_delta;
    logic [TW-1:0] s1_target;
    logic        s1_index_fault;
    t_result     s1_res;

    t_result     s2_res;
    logic        rf_we;

    logic          dmem_we;
    logic [AW-1:0] dmem_waddr;
    logic [31:0]   dmem_wdata;
    logic          dmem_re;

    assign in_xfer  = i_instr.valid && i_instr.ready;
    assign out_xfer = o_result.valid && o_result.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    assign i_instr.ready = !r_clearing && (r_credit != (FW+1)'(FD));
    assign i_cfg.ready   = 1'b1;

    // register file copies, one per source operand
    rv32ss_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.dest_reg),
        .i_wdata (s2_res.write_value),
        .i_re    (in_xfer),
        .i_raddr (i_instr.instruction[19:15]),
        .o_rdata (rf1_q)
    );

    rv32ss_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.dest_reg),
        .i_wdata (s2_res.write_value),
        .i_re    (in_xfer),
        .i_raddr (i_instr.instruction[24:20]),
        .o_rdata (rf2_q)
    );

    // data memory
    rv32ss_ram #(.WIDTH(32), .DEPTH(DMEM_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dmem_we),
        .i_waddr (dmem_waddr),
        .i_wdata (dmem_wdata),
        .i_re    (dmem_re),
        .i_raddr (s1_addr[AW-1:0]),
        .o_rdata (dmem_q)
    );

    // pick operands: newest write first, then the write of the last edge, then RAM
    always_comb begin
        s1_rs1 = r_s1_instr[19:15];
        s1_rs2 = r_s1_instr[24:20];
        if (s1_rs1 == 5'd0) begin
            s1_a = '0;
        end else if (r_s2_valid && r_s2.reg_written && (r_s2.dest_reg == s1_rs1)) begin
            s1_a = s2_res.write_value;
        end else if (r_wb_valid && (r_wb_rd == s1_rs1)) begin
            s1_a = r_wb_value;
        end else if (r_rf_valid[s1_rs1]) begin
            s1_a = rf1_q;
        end else begin
            s1_a = '0;
        end
        if (s1_rs2 == 5'd0) begin
            s1_b = '0;
        end else if (r_s2_valid && r_s2.reg_written && (r_s2.dest_reg == s1_rs2)) begin
            s1_b = s2_res.write_value;
        end else if (r_wb_valid && (r_wb_rd == s1_rs2)) begin
            s1_b = r_wb_value;
        end else if (r_rf_valid[s1_rs2]) begin
            s1_b = rf2_q;
        end else begin
            s1_b = '0;
        end
    end

    // decode
    always_comb begin
        s1_opc       = r_s1_instr[6:0];
        s1_rd        = r_s1_instr[11:7];
        s1_f3        = r_s1_instr[14:12];
        s1_is_load   = 1'b0;
        s1_is_store  = 1'b0;
        s1_is_alu    = 1'b0;
        s1_is_op     = 1'b0;
        s1_is_branch = 1'b0;
        s1_illegal   = 1'b0;
        case (s1_opc)
            rv32ss_pkg::OPC_LOAD:   s1_is_load   = 1'b1;
            rv32ss_pkg::OPC_STORE:  s1_is_store  = 1'b1;
            rv32ss_pkg::OPC_OP: begin
                s1_is_alu = 1'b1;
                s1_is_op  = 1'b1;
            end
            rv32ss_pkg::OPC_OPIMM:  s1_is_alu    = 1'b1;
            rv32ss_pkg::OPC_BRANCH: s1_is_branch = 1'b1;
            default:                s1_illegal   = 1'b1;
        endcase
    end

    // address, ALU and branch
    always_comb begin
        s1_imm_i = {{20{r_s1_instr[31]}}, r_s1_instr[31:20]};
        s1_imm_s = {{20{r_s1_instr[31]}}, r_s1_instr[31:25], r_s1_instr[11:7]};
        s1_addr  = s1_a + (s1_is_store ? s1_imm_s : s1_imm_i);
        s1_mem_fault = (s1_is_load || s1_is_store) && (s1_addr >= 32'(DMEM_DEPTH));

        s1_op2 = s1_is_op ? s1_b : s1_imm_i;
        if (s1_is_op && r_s1_instr[30]) begin
            s1_alu = (s1_f3 == rv32ss_pkg::F3_ADD) ? (s1_a - s1_op2) : '0;
        end else begin
            case (s1_f3)
                rv32ss_pkg::F3_ADD: s1_alu = s1_a + s1_op2;
                rv32ss_pkg::F3_AND: s1_alu = s1_a & s1_op2;
                rv32ss_pkg::F3_OR:  s1_alu = s1_a | s1_op2;
                default:            s1_alu = '0;
            endcase
        end

        s1_wr = (s1_is_alu || (s1_is_load && !s1_mem_fault)) && (s1_rd != 5'd0);

        // taken beq moves by the byte offset shifted down arithmetically by two
        s1_taken  = s1_is_branch && (s1_a == s1_b);
        s1_boff   = {r_s1_instr[31], r_s1_instr[7], r_s1_instr[30:25],
                     r_s1_instr[11:8], 1'b0};
        s1_delta  = s1_taken ? s1_boff[12:2] : 11'd1;
        s1_target = {{(TW-IW){1'b0}}, r_index} + {{(TW-11){s1_delta[10]}}, s1_delta};
        s1_index_fault = s1_target[TW-1] ||
                         (s1_target >= {{(TW-rv32ss_pkg::CFG_W){1'b0}}, r_prog_len});

        s1_res.next_index   = s1_target[IW-1:0];
        s1_res.index_fault  = s1_index_fault;
        s1_res.illegal      = s1_illegal;
        s1_res.reg_written  = s1_wr;
        s1_res.dest_reg     = s1_wr ? s1_rd : 5'd0;
        s1_res.write_value  = (s1_wr && s1_is_alu) ? s1_alu : '0;
        s1_res.mem_written  = s1_is_store && !s1_mem_fault;
        s1_res.mem_fault    = s1_mem_fault;
        s1_res.branch_taken = s1_taken;
    end

    // data memory port: clearing pass, else the store of the execute step
    always_comb begin
        dmem_we    = r_clearing || (r_s1_valid && s1_res.mem_written);
        dmem_waddr = r_clearing ? r_clr_addr : s1_addr[AW-1:0];
        dmem_wdata = r_clearing ? '0 : s1_b;
        dmem_re    = r_s1_valid && s1_is_load && !s1_mem_fault;
    end

    // merge load data into the write-back
    always_comb begin
        s2_res = r_s2;
        if (r_s2_load) begin
            s2_res.write_value = dmem_q;
        end
        rf_we = r_s2_valid && r_s2.reg_written;
    end

    // clear the data memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DMEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // program length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= rv32ss_pkg::PROG_LEN_RESET;
        end else if (cfg_xfer) begin
            r_prog_len <= i_cfg.program_length;
        end
    end

    // advance the flow: read, execute, write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_index    <= '0;
            r_rf_valid <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_xfer;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_index <= s1_res.next_index;
            end
            if (rf_we) begin
                r_rf_valid[r_s2.dest_reg] <= 1'b1;
                r_wb_valid                <= 1'b1;
            end
        end
    end

    // payload of the flow
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_instr <= i_instr.instruction;
        end
        if (r_s1_valid) begin
            r_s2      <= s1_res;
            r_s2_load <= s1_is_load && s1_wr;
        end
        if (rf_we) begin
            r_wb_rd    <= r_s2.dest_reg;
            r_wb_value <= s2_res.write_value;
        end
    end

    // result queue and credit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
            r_credit <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (out_xfer) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count  <= r_count + (FW+1)'(r_s2_valid) - (FW+1)'(out_xfer);
            r_credit <= r_credit + (FW+1)'(in_xfer) - (FW+1)'(out_xfer);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_wptr] <= s2_res;
        end
    end

    // drive the result channel from the queue head
    assign o_result.valid        = (r_count != '0);
    assign o_result.next_index   = r_fifo[r_rptr].next_index;
    assign o_result.index_fault  = r_fifo[r_rptr].index_fault;
    assign o_result.illegal      = r_fifo[r_rptr].illegal;
    assign o_result.reg_written  = r_fifo[r_rptr].reg_written;
    assign o_result.dest_reg     = r_fifo[r_rptr].dest_reg;
    assign o_result.write_value  = $signed(r_fifo[r_rptr].write_value);
    assign o_result.mem_written  = r_fifo[r_rptr].mem_written;
    assign o_result.mem_fault    = r_fifo[r_rptr].mem_fault;
    assign o_result.branch_taken = r_fifo[r_rptr].branch_taken;

    // queue never takes a push while full and not draining
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_xfer) |-> (r_count != (FW+1)'(FD)))
        else $error("result queue overflow");

    // every queued result is covered by an outstanding credit
    a_credit_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit >= r_count)
        else $error("credit count below queue fill");

    // no instruction is in flight while the data memory is being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_valid && !r_s2_valid))
        else $error("instruction in flight during memory clear");

    // x0 is never a write-back target
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (r_s2.dest_reg != 5'd0))
        else $error("write-back to x0");

endmodule
